/* src/jise_pkg.sv */
// jise_pkg: shared constants, types, codes and the branch test for the stack engine
// no dependencies
package jise_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LOCAL_COUNT = 256;
    localparam int DATA_W      = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int LA_W        = $clog2(LOCAL_COUNT);

    typedef enum logic [3:0] {
        CMD_PUSH   = 4'd0,
        CMD_LOAD   = 4'd1,
        CMD_STORE  = 4'd2,
        CMD_ADD    = 4'd3,
        CMD_SUB    = 4'd4,
        CMD_MUL    = 4'd5,
        CMD_DIV    = 4'd6,
        CMD_DUP    = 4'd7,
        CMD_SWAP   = 4'd8,
        CMD_POP    = 4'd9,
        CMD_CMPBR  = 4'd10,
        CMD_ZEROBR = 4'd11,
        CMD_GOTO   = 4'd12
    } cmd_code_t;

    typedef enum logic [2:0] {
        COND_EQ = 3'd0,
        COND_NE = 3'd1,
        COND_LT = 3'd2,
        COND_GE = 3'd3,
        COND_GT = 3'd4,
        COND_LE = 3'd5
    } cond_code_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIV0  = 2'd3
    } err_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_READ2,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [15:0] immediate;
        logic [7:0]         local_index;
        logic [2:0]         condition;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [6:0]         stack_depth;
        logic               branch_taken;
        logic signed [15:0] branch_offset;
        logic [1:0]         error_code;
    } res_t;

    function automatic logic cond_test(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b,
                                       input logic [2:0] cond);
        logic lt;
        logic eq;
        logic r;
        lt = $signed(a) < $signed(b);
        eq = a == b;
        case (cond)
            COND_EQ: r = eq;
            COND_NE: r = !eq;
            COND_LT: r = lt;
            COND_GE: r = !lt;
            COND_GT: r = !lt && !eq;
            COND_LE: r = lt || eq;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* src/jise_cmd_if.sv */
// jise_cmd_if: valid/ready channel carrying one decoded instruction word
// depends on jise_pkg
interface jise_cmd_if;
    logic             valid;
    logic             ready;
    jise_pkg::cmd_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/jise_res_if.sv */
// jise_res_if: valid/ready channel carrying one result word
// depends on jise_pkg
interface jise_res_if;
    logic             valid;
    logic             ready;
    jise_pkg::res_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/jise_ram.sv */
// jise_ram: generic single write port, single read port ram with registered read
// no dependencies
module jise_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/jise_div.sv */
// jise_div: unsigned restoring divider, one quotient bit per cycle
// depends on jise_pkg
module jise_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [jise_pkg::DATA_W-1:0] dividend,
    input  logic [jise_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [jise_pkg::DATA_W-1:0] quotient
);
    import jise_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // trial subtract, keep it when no borrow
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* src/jvm_integer_stack_engine.sv */
// jvm_integer_stack_engine: integer bytecode stack engine, top level
// depends on jise_pkg, jise_cmd_if, jise_res_if, jise_ram, jise_div
//
//   port  | dir | word                                  | handshake
//   ------+-----+---------------------------------------+------------
//   cmd   | in  | command, immediate, local_index, cond | valid/ready
//   res   | out | top, depth, branch, offset, error     | valid/ready
//
// most instructions are accepted in idle and complete in the read state
// cmpbranch adds a second read state (a second stack read fetches the new top)
// div starts the bit-serial divider in the read state, ends when it is done
// reset empties the stack; stack and local memories are not cleared
// a result waits in the output register; a stalled result sink holds the engine
// only when the next result is ready to be written
module jvm_integer_stack_engine (
    input  logic       clk,
    input  logic       rst_n,
    jise_cmd_if.sink   cmd,
    jise_res_if.source res
);
    import jise_pkg::*;

    // top of stack lives in a register, entries below it in the stack ram
    state_t            state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [3:0]        cmd_reg;
    logic [15:0]       imm_reg;
    logic [LA_W-1:0]   idx_reg;
    logic [2:0]        cond_reg;
    logic              taken_reg, taken_next;
    logic [1:0]        err_reg, err_next;
    logic              neg_reg, neg_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_data_reg, res_data_next;

    // memory ports
    logic              st_we;
    logic [SA_W-1:0]   st_waddr;
    logic [DATA_W-1:0] st_wdata;
    logic [SA_W-1:0]   st_raddr;
    logic [DATA_W-1:0] st_rdata;
    logic              lc_we;
    logic [DATA_W-1:0] lc_rdata;

    // divider
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_a, div_b, div_q;

    logic              accept;
    logic              out_free;
    logic              fin;
    logic [DATA_W-1:0] imm_ext;
    logic [SP_W-1:0]   sp_m1, sp_m2, sp_m3;
    logic [DATA_W-1:0] sum, dif;
    logic [DATA_W-1:0] prod;

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !res_valid_reg || res.ready;
    assign imm_ext  = {{(DATA_W-16){imm_reg[15]}}, imm_reg};
    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_m2    = sp_reg - SP_W'(2);
    assign sp_m3    = sp_reg - SP_W'(3);
    assign sum      = st_rdata + top_reg;
    assign dif      = st_rdata - top_reg;
    assign prod     = DATA_W'(st_rdata * top_reg);

    assign cmd.ready = state_reg == S_IDLE;

    // second entry on accept, third entry for cmpbranch
    assign st_raddr = (state_reg == S_READ) ? sp_m3[SA_W-1:0] : sp_m2[SA_W-1:0];

    // magnitudes for the unsigned divider
    assign div_a = st_rdata[DATA_W-1] ? DATA_W'(0) - st_rdata : st_rdata;
    assign div_b = top_reg[DATA_W-1]  ? DATA_W'(0) - top_reg  : top_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd_reg == CMD_CMPBR && sp_reg >= SP_W'(2))
                begin
                    state_next = S_READ2;
                end
                else if (cmd_reg == CMD_DIV && sp_reg >= SP_W'(2) && top_reg != '0)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = out_free ? S_IDLE : S_DONE;
                end
            end
            S_READ2:
            begin
                state_next = out_free ? S_IDLE : S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = out_free ? S_IDLE : S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        sp_next    = sp_reg;
        top_next   = top_reg;
        taken_next = taken_reg;
        err_next   = err_reg;
        neg_next   = neg_reg;
        st_we      = 1'b0;
        st_waddr   = sp_m1[SA_W-1:0];
        st_wdata   = top_reg;
        lc_we      = 1'b0;
        div_start  = 1'b0;
        fin        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                taken_next = 1'b0;
                err_next   = ERR_OK;
            end
            S_READ:
            begin
                fin = 1'b1;
                case (cmd_reg)
                    CMD_PUSH, CMD_LOAD, CMD_DUP:
                    begin
                        if (cmd_reg == CMD_DUP && sp_reg == '0)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else if (sp_reg >= SP_W'(STACK_DEPTH))
                        begin
                            err_next = ERR_OVER;
                        end
                        else
                        begin
                            // spill the old top below the new one
                            st_we   = sp_reg != '0;
                            sp_next = sp_reg + SP_W'(1);
                            if (cmd_reg == CMD_PUSH)
                            begin
                                top_next = imm_ext;
                            end
                            else if (cmd_reg == CMD_LOAD)
                            begin
                                top_next = lc_rdata;
                            end
                        end
                    end
                    CMD_STORE:
                    begin
                        if (sp_reg == '0)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            lc_we    = 1'b1;
                            top_next = st_rdata;
                            sp_next  = sp_m1;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                    begin
                        if (sp_reg < SP_W'(2))
                        begin
                            err_next = ERR_UNDER;
                        end
                        else if (cmd_reg == CMD_DIV)
                        begin
                            if (top_reg == '0)
                            begin
                                err_next = ERR_DIV0;
                            end
                            else
                            begin
                                fin       = 1'b0;
                                div_start = 1'b1;
                                neg_next  = st_rdata[DATA_W-1] ^ top_reg[DATA_W-1];
                            end
                        end
                        else
                        begin
                            sp_next = sp_m1;
                            if (cmd_reg == CMD_ADD)
                            begin
                                top_next = sum;
                            end
                            else if (cmd_reg == CMD_SUB)
                            begin
                                top_next = dif;
                            end
                            else
                            begin
                                top_next = prod;
                            end
                        end
                    end
                    CMD_SWAP:
                    begin
                        if (sp_reg < SP_W'(2))
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            st_we    = 1'b1;
                            st_waddr = sp_m2[SA_W-1:0];
                            top_next = st_rdata;
                        end
                    end
                    CMD_POP:
                    begin
                        if (sp_reg == '0)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            top_next = st_rdata;
                            sp_next  = sp_m1;
                        end
                    end
                    CMD_CMPBR:
                    begin
                        if (sp_reg < SP_W'(2))
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            fin        = 1'b0;
                            taken_next = cond_test(st_rdata, top_reg, cond_reg);
                        end
                    end
                    CMD_ZEROBR:
                    begin
                        if (sp_reg == '0)
                        begin
                            err_next = ERR_UNDER;
                        end
                        else
                        begin
                            taken_next = cond_test(top_reg, '0, cond_reg);
                            top_next   = st_rdata;
                            sp_next    = sp_m1;
                        end
                    end
                    CMD_GOTO:
                    begin
                        taken_next = 1'b1;
                    end
                    default:
                    begin
                        err_next = ERR_OK;
                    end
                endcase
            end
            S_READ2:
            begin
                fin      = 1'b1;
                top_next = st_rdata;
                sp_next  = sp_m2;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    fin      = 1'b1;
                    top_next = neg_reg ? DATA_W'(0) - div_q : div_q;
                    sp_next  = sp_m1;
                end
            end
            S_DONE:
            begin
                fin = 1'b1;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    // result word built from the post-step state
    always_comb
    begin
        res_data_next.top_value     = (sp_next != '0) ? top_next : '0;
        res_data_next.stack_depth   = 7'(sp_next);
        res_data_next.branch_taken  = taken_next;
        res_data_next.branch_offset = taken_next ? imm_reg : 16'd0;
        res_data_next.error_code    = err_next;
        if (fin && out_free)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            res_valid_reg <= 1'b0;
            taken_reg     <= 1'b0;
            err_reg       <= ERR_OK;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            res_valid_reg <= res_valid_next;
            taken_reg     <= taken_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        neg_reg <= neg_next;
        if (accept)
        begin
            cmd_reg  <= cmd.data.command;
            imm_reg  <= cmd.data.immediate;
            idx_reg  <= cmd.data.local_index[LA_W-1:0];
            cond_reg <= cmd.data.condition;
        end
        if (fin && out_free)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    jise_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    jise_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LOCAL_COUNT)
    ) u_local_ram (
        .clk   (clk),
        .we    (lc_we),
        .waddr (idx_reg),
        .wdata (top_reg),
        .raddr (cmd.data.local_index[LA_W-1:0]),
        .rdata (lc_rdata)
    );

    jise_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );
endmodule

/* src/jise_chk.sv */
// jise_chk: port-level checks on the stack engine result channel, bound to the top level
// depends on jise_pkg and jvm_integer_stack_engine
module jise_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_ready,
    input jise_pkg::res_t res_data
);
    import jise_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    a_err_no_branch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.error_code != ERR_OK |-> !res_data.branch_taken)
        else $error("branch reported on a failed step");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.branch_taken |-> res_data.branch_offset == 16'sd0)
        else $error("offset without a taken branch");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.stack_depth == 7'd0 |-> res_data.top_value == 32'sd0)
        else $error("nonzero top on an empty stack");
endmodule

bind jvm_integer_stack_engine jise_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
